FILE: src/compact_timestamp_decoder_unit_macros.svh
// assertion macros for the compact timestamp decoder checker
// no dependencies; included by the checker file
`ifndef COMPACT_TIMESTAMP_DECODER_UNIT_MACROS_SVH
`define COMPACT_TIMESTAMP_DECODER_UNIT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define CTD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds across reset
`define CTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/ctd_pkg.sv
// types, constants and helper functions for the compact timestamp decoder
// no dependencies; used by every module of the block
`default_nettype none

package ctd_pkg;

   localparam int NumDigits  = 14;
   localparam int NumPairs   = NumDigits / 2;
   localparam int PairWidth  = 7;

   localparam logic [6:0]  PivotReset  = 7'd70;
   localparam logic [10:0] YearBase19  = 11'd1900;
   localparam logic [10:0] YearBase20  = 11'd2000;
   localparam logic [6:0]  Century19   = 7'd19;
   localparam logic [6:0]  Century20   = 7'd20;
   localparam logic [6:0]  LateYearMax = 7'd35;
   localparam logic [6:0]  DayFreeMax  = 7'd31;
   localparam logic [6:0]  HourLimit   = 7'd24;
   localparam logic [6:0]  MinSecLimit = 7'd60;
   localparam logic [6:0]  MonthMax    = 7'd12;
   localparam logic [3:0]  DigitMax    = 4'd9;
   localparam logic [3:0]  MinCount    = 4'd6;

   localparam logic [5:0] MaskSec   = 6'b000001;
   localparam logic [5:0] MaskMin   = 6'b000010;
   localparam logic [5:0] MaskHour  = 6'b000100;
   localparam logic [5:0] MaskDay   = 6'b001000;
   localparam logic [5:0] MaskMonth = 6'b010000;
   localparam logic [5:0] MaskYear  = 6'b100000;

   // layouts in priority order
   typedef enum logic [3:0] {
      LAY_Y4MDHMS = 4'd0,
      LAY_Y4MDHM  = 4'd1,
      LAY_Y2MDHMS = 4'd2,
      LAY_MDHMS   = 4'd3,
      LAY_Y2MDHM  = 4'd4,
      LAY_Y4MDH   = 4'd5,
      LAY_MDHM    = 4'd6,
      LAY_Y4MD    = 4'd7,
      LAY_DHMS    = 4'd8,
      LAY_Y2MDH   = 4'd9,
      LAY_Y2MD    = 4'd10,
      LAY_Y4M     = 4'd11,
      LAY_HMS     = 4'd12,
      LAY_DHM     = 4'd13,
      LAY_MDH     = 4'd14
   } layout_type;

   localparam int NumLayouts = 15;

   typedef struct packed {
      logic [55:0] digits_bcd;
      logic [3:0]  digit_count;
   } req_type;

   typedef struct packed {
      logic [5:0]  field_mask;
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } rsp_type;

   // after the digit stage: two-digit values and length checks
   typedef struct packed {
      logic [NumPairs-1:0][PairWidth-1:0] pair;
      logic                               digits_ok;
      logic [3:0]                         digit_count;
   } pair_type;

   // after the check stage: per-layout pass bits and year candidates
   typedef struct packed {
      logic [NumPairs-1:0][PairWidth-1:0] pair;
      logic [NumLayouts-1:0]              pass;
      logic [10:0]                        year4;
      logic [10:0]                        year2;
   } check_type;

   function automatic logic [4:0] month_limit(input logic [6:0] mo);
      logic [4:0] lim;
      lim = 5'd31;
      if (mo == 7'd2) begin
         lim = 5'd29;
      end else if (mo inside {7'd4, 7'd6, 7'd9, 7'd11}) begin
         lim = 5'd30;
      end
      return lim;
   endfunction

   function automatic logic month_ok(input logic [6:0] mo);
      return (mo != 7'd0) && (mo <= MonthMax);
   endfunction

   function automatic logic month_day_ok(input logic [6:0] mo, input logic [6:0] dy);
      return month_ok(mo) && (dy <= {2'b00, month_limit(mo)});
   endfunction

endpackage

`default_nettype wire

FILE: src/ctd_pair_stage.sv
// first pipeline stage: bcd pairs to binary, digit and length checks
// depends on ctd_pkg
`default_nettype none

module ctd_pair_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              valid_in,
   input  wire ctd_pkg::req_type  data_in,
   output logic                   valid_ff,
   output ctd_pkg::pair_type      data_ff
);

   ctd_pkg::pair_type data_in_c;

   always_comb begin
      logic [3:0] hi;
      logic [3:0] lo;
      logic [7:0] sum;
      logic       all_ok;
      data_in_c = '0;
      all_ok    = 1'b1;
      for (int i = 0; i < ctd_pkg::NumDigits; i++) begin
         // only digits inside the count must be decimal
         if (data_in.digits_bcd[55 - 4*i -: 4] > ctd_pkg::DigitMax &&
             4'(i) < data_in.digit_count) begin
            all_ok = 1'b0;
         end
      end
      for (int k = 0; k < ctd_pkg::NumPairs; k++) begin
         hi  = data_in.digits_bcd[55 - 8*k -: 4];
         lo  = data_in.digits_bcd[51 - 8*k -: 4];
         sum = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
         data_in_c.pair[k] = sum[ctd_pkg::PairWidth-1:0];
      end
      data_in_c.digits_ok   = all_ok && (data_in.digit_count >= ctd_pkg::MinCount) &&
                              !data_in.digit_count[0];
      data_in_c.digit_count = data_in.digit_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in_c;
      end
   end

endmodule

`default_nettype wire

FILE: src/ctd_check_stage.sv
// second pipeline stage: field range checks and per-layout pass bits
// depends on ctd_pkg
`default_nettype none

module ctd_check_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic [6:0]         century_pivot,
   input  wire logic               valid_in,
   input  wire ctd_pkg::pair_type  data_in,
   output logic                    valid_ff,
   output ctd_pkg::check_type      data_ff
);

   ctd_pkg::check_type data_in_c;

   always_comb begin
      logic [ctd_pkg::NumPairs-1:0] lt24;
      logic [ctd_pkg::NumPairs-1:0] lt60;
      logic [2:0]                   md;
      logic                         y4ok;
      logic                         y2ok;
      logic                         dfree;
      logic                         mo2;
      logic                         ok6, ok8, ok10, ok12, ok14;
      logic [6:0]                   p0, p1;

      p0 = data_in.pair[0];
      p1 = data_in.pair[1];
      for (int k = 0; k < ctd_pkg::NumPairs; k++) begin
         lt24[k] = data_in.pair[k] < ctd_pkg::HourLimit;
         lt60[k] = data_in.pair[k] < ctd_pkg::MinSecLimit;
      end
      for (int k = 0; k < 3; k++) begin
         md[k] = ctd_pkg::month_day_ok(data_in.pair[k], data_in.pair[k+1]);
      end
      mo2   = ctd_pkg::month_ok(data_in.pair[2]);
      dfree = p0 <= ctd_pkg::DayFreeMax;
      y4ok  = (p0 == ctd_pkg::Century19) ||
              ((p0 == ctd_pkg::Century20) && (p1 <= ctd_pkg::LateYearMax));
      y2ok  = (p0 >= century_pivot) || (p0 <= ctd_pkg::LateYearMax);

      ok6  = data_in.digits_ok && (data_in.digit_count == 4'd6);
      ok8  = data_in.digits_ok && (data_in.digit_count == 4'd8);
      ok10 = data_in.digits_ok && (data_in.digit_count == 4'd10);
      ok12 = data_in.digits_ok && (data_in.digit_count == 4'd12);
      ok14 = data_in.digits_ok && (data_in.digit_count == 4'd14);

      data_in_c      = '0;
      data_in_c.pair = data_in.pair;
      data_in_c.pass[ctd_pkg::LAY_Y4MDHMS] = ok14 && y4ok && md[2] && lt24[4] && lt60[5] &&
                                             lt60[6];
      data_in_c.pass[ctd_pkg::LAY_Y4MDHM]  = ok12 && y4ok && md[2] && lt24[4] && lt60[5];
      data_in_c.pass[ctd_pkg::LAY_Y2MDHMS] = ok12 && y2ok && md[1] && lt24[3] && lt60[4] &&
                                             lt60[5];
      data_in_c.pass[ctd_pkg::LAY_MDHMS]   = ok10 && md[0] && lt24[2] && lt60[3] && lt60[4];
      data_in_c.pass[ctd_pkg::LAY_Y2MDHM]  = ok10 && y2ok && md[1] && lt24[3] && lt60[4];
      data_in_c.pass[ctd_pkg::LAY_Y4MDH]   = ok10 && y4ok && md[2] && lt24[4];
      data_in_c.pass[ctd_pkg::LAY_MDHM]    = ok8 && md[0] && lt24[2] && lt60[3];
      data_in_c.pass[ctd_pkg::LAY_Y4MD]    = ok8 && y4ok && md[2];
      data_in_c.pass[ctd_pkg::LAY_DHMS]    = ok8 && dfree && lt24[1] && lt60[2] && lt60[3];
      data_in_c.pass[ctd_pkg::LAY_Y2MDH]   = ok8 && y2ok && md[1] && lt24[3];
      data_in_c.pass[ctd_pkg::LAY_Y2MD]    = ok6 && y2ok && md[1];
      data_in_c.pass[ctd_pkg::LAY_Y4M]     = ok6 && y4ok && mo2;
      data_in_c.pass[ctd_pkg::LAY_HMS]     = ok6 && lt24[0] && lt60[1] && lt60[2];
      data_in_c.pass[ctd_pkg::LAY_DHM]     = ok6 && dfree && lt24[1] && lt60[2];
      data_in_c.pass[ctd_pkg::LAY_MDH]     = ok6 && md[0] && lt24[2];

      // four-digit year: century pair is 19 or 20 whenever it passes
      data_in_c.year4 = ((p0 == ctd_pkg::Century19) ? ctd_pkg::YearBase19
                                                    : ctd_pkg::YearBase20) + {4'd0, p1};
      // two-digit year pivoted by the register
      data_in_c.year2 = ((p0 >= century_pivot) ? ctd_pkg::YearBase19
                                               : ctd_pkg::YearBase20) + {4'd0, p0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in_c;
      end
   end

endmodule

`default_nettype wire

FILE: src/ctd_select_stage.sv
// third pipeline stage: first passing layout picks the result, output register
// depends on ctd_pkg
`default_nettype none

module ctd_select_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire logic                valid_in,
   input  wire ctd_pkg::check_type  data_in,
   output logic                     valid_ff,
   output ctd_pkg::rsp_type         data_ff
);

   ctd_pkg::rsp_type    data_in_c;
   ctd_pkg::layout_type sel;
   logic                found;

   always_comb begin
      found = 1'b0;
      sel   = ctd_pkg::LAY_Y4MDHMS;
      for (int i = 0; i < ctd_pkg::NumLayouts; i++) begin
         if (!found && data_in.pass[i]) begin
            found = 1'b1;
            sel   = ctd_pkg::layout_type'(4'(i));
         end
      end
   end

   always_comb begin
      logic [ctd_pkg::NumPairs-1:0][ctd_pkg::PairWidth-1:0] p;
      p = data_in.pair;
      data_in_c              = '0;
      data_in_c.day_of_month = 5'd1;
      if (found) begin
         case (sel)
            ctd_pkg::LAY_Y4MDHMS: begin
               data_in_c.field_mask   = ctd_pkg::MaskYear | ctd_pkg::MaskMonth |
                                        ctd_pkg::MaskDay | ctd_pkg::MaskHour |
                                        ctd_pkg::MaskMin | ctd_pkg::MaskSec;
               data_in_c.year         = data_in.year4;
               data_in_c.month        = 4'(p[2]);
               data_in_c.day_of_month = 5'(p[3]);
               data_in_c.hour         = 5'(p[4]);
               data_in_c.minute       = 6'(p[5]);
               data_in_c.second       = 6'(p[6]);
            end
            ctd_pkg::LAY_Y4MDHM: begin
               data_in_c.field_mask   = ctd_pkg::MaskYear | ctd_pkg::MaskMonth |
                                        ctd_pkg::MaskDay | ctd_pkg::MaskHour |
                                        ctd_pkg::MaskMin;
               data_in_c.year         = data_in.year4;
               data_in_c.month        = 4'(p[2]);
               data_in_c.day_of_month = 5'(p[3]);
               data_in_c.hour         = 5'(p[4]);
               data_in_c.minute       = 6'(p[5]);
            end
            ctd_pkg::LAY_Y2MDHMS: begin
               data_in_c.field_mask   = ctd_pkg::MaskYear | ctd_pkg::MaskMonth |
                                        ctd_pkg::MaskDay | ctd_pkg::MaskHour |
                                        ctd_pkg::MaskMin | ctd_pkg::MaskSec;
               data_in_c.year         = data_in.year2;
               data_in_c.month        = 4'(p[1]);
               data_in_c.day_of_month = 5'(p[2]);
               data_in_c.hour         = 5'(p[3]);
               data_in_c.minute       = 6'(p[4]);
               data_in_c.second       = 6'(p[5]);
            end
            ctd_pkg::LAY_MDHMS: begin
               data_in_c.field_mask   = ctd_pkg::MaskMonth | ctd_pkg::MaskDay |
                                        ctd_pkg::MaskHour | ctd_pkg::MaskMin |
                                        ctd_pkg::MaskSec;
               data_in_c.month        = 4'(p[0]);
               data_in_c.day_of_month = 5'(p[1]);
               data_in_c.hour         = 5'(p[2]);
               data_in_c.minute       = 6'(p[3]);
               data_in_c.second       = 6'(p[4]);
            end
            ctd_pkg::LAY_Y2MDHM: begin
               data_in_c.field_mask   = ctd_pkg::MaskYear | ctd_pkg::MaskMonth |
                                        ctd_pkg::MaskDay | ctd_pkg::MaskHour |
                                        ctd_pkg::MaskMin;
               data_in_c.year         = data_in.year2;
               data_in_c.month        = 4'(p[1]);
               data_in_c.day_of_month = 5'(p[2]);
               data_in_c.hour         = 5'(p[3]);
               data_in_c.minute       = 6'(p[4]);
            end
            ctd_pkg::LAY_Y4MDH: begin
               data_in_c.field_mask   = ctd_pkg::MaskYear | ctd_pkg::MaskMonth |
                                        ctd_pkg::MaskDay | ctd_pkg::MaskHour;
               data_in_c.year         = data_in.year4;
               data_in_c.month        = 4'(p[2]);
               data_in_c.day_of_month = 5'(p[3]);
               data_in_c.hour         = 5'(p[4]);
            end
            ctd_pkg::LAY_MDHM: begin
               data_in_c.field_mask   = ctd_pkg::MaskMonth | ctd_pkg::MaskDay |
                                        ctd_pkg::MaskHour | ctd_pkg::MaskMin;
               data_in_c.month        = 4'(p[0]);
               data_in_c.day_of_month = 5'(p[1]);
               data_in_c.hour         = 5'(p[2]);
               data_in_c.minute       = 6'(p[3]);
            end
            ctd_pkg::LAY_Y4MD: begin
               data_in_c.field_mask   = ctd_pkg::MaskYear | ctd_pkg::MaskMonth |
                                        ctd_pkg::MaskDay;
               data_in_c.year         = data_in.year4;
               data_in_c.month        = 4'(p[2]);
               data_in_c.day_of_month = 5'(p[3]);
            end
            ctd_pkg::LAY_DHMS: begin
               data_in_c.field_mask   = ctd_pkg::MaskDay | ctd_pkg::MaskHour |
                                        ctd_pkg::MaskMin | ctd_pkg::MaskSec;
               data_in_c.day_of_month = 5'(p[0]);
               data_in_c.hour         = 5'(p[1]);
               data_in_c.minute       = 6'(p[2]);
               data_in_c.second       = 6'(p[3]);
            end
            ctd_pkg::LAY_Y2MDH: begin
               data_in_c.field_mask   = ctd_pkg::MaskYear | ctd_pkg::MaskMonth |
                                        ctd_pkg::MaskDay | ctd_pkg::MaskHour;
               data_in_c.year         = data_in.year2;
               data_in_c.month        = 4'(p[1]);
               data_in_c.day_of_month = 5'(p[2]);
               data_in_c.hour         = 5'(p[3]);
            end
            ctd_pkg::LAY_Y2MD: begin
               data_in_c.field_mask   = ctd_pkg::MaskYear | ctd_pkg::MaskMonth |
                                        ctd_pkg::MaskDay;
               data_in_c.year         = data_in.year2;
               data_in_c.month        = 4'(p[1]);
               data_in_c.day_of_month = 5'(p[2]);
            end
            ctd_pkg::LAY_Y4M: begin
               data_in_c.field_mask   = ctd_pkg::MaskYear | ctd_pkg::MaskMonth;
               data_in_c.year         = data_in.year4;
               data_in_c.month        = 4'(p[2]);
            end
            ctd_pkg::LAY_HMS: begin
               data_in_c.field_mask   = ctd_pkg::MaskHour | ctd_pkg::MaskMin |
                                        ctd_pkg::MaskSec;
               data_in_c.hour         = 5'(p[0]);
               data_in_c.minute       = 6'(p[1]);
               data_in_c.second       = 6'(p[2]);
            end
            ctd_pkg::LAY_DHM: begin
               data_in_c.field_mask   = ctd_pkg::MaskDay | ctd_pkg::MaskHour |
                                        ctd_pkg::MaskMin;
               data_in_c.day_of_month = 5'(p[0]);
               data_in_c.hour         = 5'(p[1]);
               data_in_c.minute       = 6'(p[2]);
            end
            ctd_pkg::LAY_MDH: begin
               data_in_c.field_mask   = ctd_pkg::MaskMonth | ctd_pkg::MaskDay |
                                        ctd_pkg::MaskHour;
               data_in_c.month        = 4'(p[0]);
               data_in_c.day_of_month = 5'(p[1]);
               data_in_c.hour         = 5'(p[2]);
            end
            default: begin
               data_in_c.field_mask = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in_c;
      end
   end

endmodule

`default_nettype wire

FILE: src/compact_timestamp_decoder_unit.sv
// top level of the compact timestamp decoder: pivot register and three-stage pipeline
// depends on ctd_pkg, ctd_pair_stage, ctd_check_stage, ctd_select_stage
//
// usage
// - req channel: one item carries up to 14 bcd digits, left-aligned, and a digit count
// - rsp channel: one item per request, a field mask and the decoded calendar fields;
//   mask 0 means no layout matched (day_of_month then reads 1, the rest 0)
// - csr port: csr_wr_en writes csr_wr_data into the century pivot;
//   write it only while no item is in flight
// - pipeline: each accepted item is registered by the pair, check and select stages
//   in turn (digit pairs, range checks, layout select; each stage ends in a register),
//   and the select stage register drives the rsp channel
// - throughput: one item per cycle unless rsp_ready stalls the three-register pipeline
// - stall: when rsp_ready is low the stages fill up and hold; req_ready drops only
//   once every stage holds an item, and nothing is lost or repeated
// - reset: synchronous, clears all stage valid bits and sets the pivot to 70
`default_nettype none

module compact_timestamp_decoder_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ctd_pkg::req_type  req_payload,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ctd_pkg::rsp_type       rsp_payload,
   // configuration
   input  wire logic              csr_wr_en,
   input  wire logic [6:0]        csr_wr_data
);

   logic [6:0]          pivot_ff;
   logic [6:0]          pivot_in;

   // stage enables: a stage moves when it is empty or the next one moves
   logic                en_pair;
   logic                en_check;
   logic                en_select;

   logic                pair_valid;
   ctd_pkg::pair_type   pair_data;
   logic                check_valid;
   ctd_pkg::check_type  check_data;

   assign pivot_in = csr_wr_en ? csr_wr_data : pivot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_ff <= ctd_pkg::PivotReset;
      end else begin
         pivot_ff <= pivot_in;
      end
   end

   assign en_select = !rsp_valid || rsp_ready;
   assign en_check  = !check_valid || en_select;
   assign en_pair   = !pair_valid || en_check;
   assign req_ready = en_pair;

   // bcd pairs to binary, digit and length checks
   ctd_pair_stage u_pair (
      .clock    (clock),
      .reset    (reset),
      .enable   (en_pair),
      .valid_in (req_valid),
      .data_in  (req_payload),
      .valid_ff (pair_valid),
      .data_ff  (pair_data)
   );

   // field range checks, one pass bit per layout
   ctd_check_stage u_check (
      .clock         (clock),
      .reset         (reset),
      .enable        (en_check),
      .century_pivot (pivot_ff),
      .valid_in      (pair_valid),
      .data_in       (pair_data),
      .valid_ff      (check_valid),
      .data_ff       (check_data)
   );

   // priority select, doubles as the output register
   ctd_select_stage u_select (
      .clock    (clock),
      .reset    (reset),
      .enable   (en_select),
      .valid_in (check_valid),
      .data_in  (check_data),
      .valid_ff (rsp_valid),
      .data_ff  (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: src/ctd_checker.sv
// port-level checker for the compact timestamp decoder, bound to the top level
// depends on ctd_pkg and compact_timestamp_decoder_unit_macros.svh
`default_nettype none
`include "compact_timestamp_decoder_unit_macros.svh"

module ctd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire ctd_pkg::rsp_type  rsp_payload
);

   // a stalled result stays put
   `CTD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "rsp item changed while stalled")

   // reset empties the pipeline
   `CTD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   // input backpressure only when the whole pipeline is full and the output stalls
   `CTD_ASSERT(a_ready_full, clock, reset, !req_ready |-> rsp_valid && !rsp_ready, "req_ready low without output stall")

   // a failed decode reports the default fields
   `CTD_ASSERT(a_fail_defaults, clock, reset, rsp_valid && rsp_payload.field_mask == 6'd0 |-> rsp_payload.year == 11'd0 && rsp_payload.month == 4'd0 && rsp_payload.day_of_month == 5'd1 && rsp_payload.hour == 5'd0 && rsp_payload.minute == 6'd0 && rsp_payload.second == 6'd0, "nonzero fields with empty mask")

   // a reported year lies in the supported window
   `CTD_ASSERT(a_year_range, clock, reset, rsp_valid && rsp_payload.field_mask[5] |-> rsp_payload.year >= ctd_pkg::YearBase19 && rsp_payload.year <= 11'd2035, "year outside window")

endmodule

bind compact_timestamp_decoder_unit ctd_checker u_ctd_checker (.*);

`default_nettype wire

FILE: tb/sv/ctd_tb_pkg.sv
// layout table, expected-field decoder and result ledger for the timestamp decoder bench
// depends on ctd_pkg for the item types, layout names and field mask bits
package ctd_tb_pkg;
   import ctd_pkg::*;

   localparam logic [6:0]  PIVOT_AT_RESET = 7'd70;
   localparam int unsigned NO_SLOT        = 99;

   // digit offset of each field within one layout, NO_SLOT when the field is absent
   typedef struct {
      int unsigned len;
      int unsigned y4, y2, mo, dy, hr, mi, se;
   } slot_map;

   function automatic slot_map slots_of(layout_type l);
      slot_map m;
      m = '{0, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT};
      case (l)
         LAY_Y4MDHMS: m = '{14, 0, NO_SLOT, 4, 6, 8, 10, 12};
         LAY_Y4MDHM:  m = '{12, 0, NO_SLOT, 4, 6, 8, 10, NO_SLOT};
         LAY_Y2MDHMS: m = '{12, NO_SLOT, 0, 2, 4, 6, 8, 10};
         LAY_MDHMS:   m = '{10, NO_SLOT, NO_SLOT, 0, 2, 4, 6, 8};
         LAY_Y2MDHM:  m = '{10, NO_SLOT, 0, 2, 4, 6, 8, NO_SLOT};
         LAY_Y4MDH:   m = '{10, 0, NO_SLOT, 4, 6, 8, NO_SLOT, NO_SLOT};
         LAY_MDHM:    m = '{8, NO_SLOT, NO_SLOT, 0, 2, 4, 6, NO_SLOT};
         LAY_Y4MD:    m = '{8, 0, NO_SLOT, 4, 6, NO_SLOT, NO_SLOT, NO_SLOT};
         LAY_DHMS:    m = '{8, NO_SLOT, NO_SLOT, NO_SLOT, 0, 2, 4, 6};
         LAY_Y2MDH:   m = '{8, NO_SLOT, 0, 2, 4, 6, NO_SLOT, NO_SLOT};
         LAY_Y2MD:    m = '{6, NO_SLOT, 0, 2, 4, NO_SLOT, NO_SLOT, NO_SLOT};
         LAY_Y4M:     m = '{6, 0, NO_SLOT, 4, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT};
         LAY_HMS:     m = '{6, NO_SLOT, NO_SLOT, NO_SLOT, NO_SLOT, 0, 2, 4};
         LAY_DHM:     m = '{6, NO_SLOT, NO_SLOT, NO_SLOT, 0, 2, 4, NO_SLOT};
         LAY_MDH:     m = '{6, NO_SLOT, NO_SLOT, 0, 2, 4, NO_SLOT, NO_SLOT};
         default:     m.len = 0;
      endcase
      return m;
   endfunction

   // february allows 29 regardless of year
   function automatic int unsigned days_in_month_cap(int unsigned mo);
      case (mo)
         2:             return 29;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic string show_fields(rsp_type f);
      return $sformatf("mask %02h %0d-%0d-%0d %0d:%0d:%0d", f.field_mask, f.year, f.month,
                       f.day_of_month, f.hour, f.minute, f.second);
   endfunction

   class stamp_ledger;
      rsp_type     pending_fields[$];
      int unsigned faults;
      logic [6:0]  pivot;
      int unsigned digit[14];

      function new();
         pivot  = PIVOT_AT_RESET;
         faults = 0;
      endfunction

      function void set_pivot(logic [6:0] value);
         pivot = value;
      endfunction

      function int unsigned pair_at(int unsigned p);
         return digit[p] * 10 + digit[p + 1];
      endfunction

      // range-checks one layout against the current digits
      function bit fits_layout(slot_map m, output rsp_type f);
         int unsigned yr;
         int unsigned v;
         int unsigned mo_v;
         yr   = 0;
         mo_v = 0;
         f = '0;
         f.day_of_month = 5'd1;
         if (m.y4 != NO_SLOT) begin
            yr = pair_at(m.y4) * 100 + pair_at(m.y4 + 2);
            f.field_mask |= MaskYear;
         end else if (m.y2 != NO_SLOT) begin
            yr = pair_at(m.y2);
            yr += (yr >= 32'(pivot)) ? 1900 : 2000;
            f.field_mask |= MaskYear;
         end
         if (((f.field_mask & MaskYear) != '0) && (yr < 1900 || yr > 2035)) return 0;
         f.year = 11'(yr);
         if (m.mo != NO_SLOT) begin
            v = pair_at(m.mo);
            if (v < 1 || v > 12) return 0;
            mo_v = v;
            f.month = 4'(v);
            f.field_mask |= MaskMonth;
         end
         if (m.dy != NO_SLOT) begin
            v = pair_at(m.dy);
            if (v > ((m.mo != NO_SLOT) ? days_in_month_cap(mo_v) : 31)) return 0;
            f.day_of_month = 5'(v);
            f.field_mask |= MaskDay;
         end
         if (m.hr != NO_SLOT) begin
            v = pair_at(m.hr);
            if (v >= 24) return 0;
            f.hour = 5'(v);
            f.field_mask |= MaskHour;
         end
         if (m.mi != NO_SLOT) begin
            v = pair_at(m.mi);
            if (v >= 60) return 0;
            f.minute = 6'(v);
            f.field_mask |= MaskMin;
         end
         if (m.se != NO_SLOT) begin
            v = pair_at(m.se);
            if (v >= 60) return 0;
            f.second = 6'(v);
            f.field_mask |= MaskSec;
         end
         return 1;
      endfunction

      function rsp_type decode_stamp(req_type r);
         rsp_type res;
         rsp_type trial;
         bit      ok;
         slot_map m;
         res = '0;
         res.day_of_month = 5'd1;
         ok = (r.digit_count >= 4'd6) && !r.digit_count[0];
         for (int i = 0; i < 14; i++) begin
            digit[i] = 32'(r.digits_bcd[55 - 4 * i -: 4]);
            if (4'(i) < r.digit_count && digit[i] > 9) ok = 0;
         end
         if (ok) begin
            for (int k = 0; k < NumLayouts; k++) begin
               m = slots_of(layout_type'(k));
               if (m.len == 32'(r.digit_count) && fits_layout(m, trial)) begin
                  res = trial;
                  break;
               end
            end
         end
         return res;
      endfunction

      function void note_stamp(req_type r);
         pending_fields.push_back(decode_stamp(r));
      endfunction

      function void check_fields(rsp_type got);
         rsp_type want;
         if (pending_fields.size() == 0) begin
            faults++;
            if (faults <= 10) $display("unexpected result: %s", show_fields(got));
            return;
         end
         want = pending_fields.pop_front();
         if (got.field_mask !== want.field_mask || got.year !== want.year ||
             got.month !== want.month || got.day_of_month !== want.day_of_month ||
             got.hour !== want.hour || got.minute !== want.minute ||
             got.second !== want.second) begin
            faults++;
            if (faults <= 10)
               $display("field mismatch: expected %s, got %s", show_fields(want),
                        show_fields(got));
         end
      endfunction

      function bit clean();
         return faults == 0 && pending_fields.size() == 0;
      endfunction
   endclass

endpackage

FILE: tb/sv/tb_top.sv
// top-level bench for compact_timestamp_decoder_unit: drives items and pivot writes
// depends on ctd_pkg, ctd_tb_pkg and the decoder rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ctd_pkg::*;
   import ctd_tb_pkg::*;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic       csr_wr_en;
   logic [6:0] csr_wr_data;

   // idle odds in percent, changed only between phases
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   stamp_ledger ledger = new();

   // hand-picked stamps: field extremes, every layout except HMS and MDH, rejected months/days,
   // non-decimal digits, odd and short lengths
   string directed_text[$] = '{
      "20351231235959", "19000101000000", "20360101000000", "20240013000000",
      "20240100120000", "20240229120000", "20240230120000", "20240101240000",
      "20240101236060", "202401011230",   "991231235959",   "690101000000",
      "1231235959",     "2401011230",     "2024010112",     "12312359",
      "20240229",       "31235959",       "99123123",       "991231",
      "202412",         "312359",         "2024A101000000", "1234567",
      "FFFFFFFFFFFFFFF", ""
   };

   compact_timestamp_decoder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // hard stop in case the pipeline hangs
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver: ready is redrawn every falling edge
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // every accepted result goes straight to the ledger
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.check_fields(rsp_payload);
   end

   // characters map to nibbles, letters give the non-decimal values
   function automatic req_type text_stamp(string s);
      req_type r;
      byte     c;
      r = '0;
      r.digit_count = 4'(s.len());
      for (int i = 0; i < s.len() && i < 14; i++) begin
         c = s[i];
         r.digits_bcd[55 - 4 * i -: 4] = 4'((c >= "A") ? c - 55 : c - 48);
      end
      return r;
   endfunction

   // mostly in range, sometimes an edge, now and then anything up to top
   function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                              int unsigned top);
      case ($urandom_range(15))
         0:       return lo;
         1:       return hi;
         2:       return $urandom_range(top, 0);
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   // stamp laid out for one layout, with random content that may fall out of range
   function automatic req_type compose_stamp(layout_type l);
      slot_map     m;
      req_type     r;
      int unsigned dig[14];
      int unsigned v;
      int unsigned mo;
      m  = slots_of(l);
      mo = 0;
      for (int i = 0; i < 14; i++) dig[i] = $urandom_range(9);
      if (m.y4 != NO_SLOT) begin
         v = pick_value(1900, 2035, 2999);
         dig[m.y4]     = v / 1000 % 10;
         dig[m.y4 + 1] = v / 100 % 10;
         dig[m.y4 + 2] = v / 10 % 10;
         dig[m.y4 + 3] = v % 10;
      end
      if (m.y2 != NO_SLOT) begin
         v = $urandom_range(99);
         dig[m.y2] = v / 10; dig[m.y2 + 1] = v % 10;
      end
      if (m.mo != NO_SLOT) begin
         mo = pick_value(1, 12, 99);
         dig[m.mo] = mo / 10; dig[m.mo + 1] = mo % 10;
      end
      if (m.dy != NO_SLOT) begin
         v = pick_value(0, (m.mo != NO_SLOT) ? days_in_month_cap(mo) : 31, 99);
         dig[m.dy] = v / 10; dig[m.dy + 1] = v % 10;
      end
      if (m.hr != NO_SLOT) begin
         v = pick_value(0, 23, 99);
         dig[m.hr] = v / 10; dig[m.hr + 1] = v % 10;
      end
      if (m.mi != NO_SLOT) begin
         v = pick_value(0, 59, 99);
         dig[m.mi] = v / 10; dig[m.mi + 1] = v % 10;
      end
      if (m.se != NO_SLOT) begin
         v = pick_value(0, 59, 99);
         dig[m.se] = v / 10; dig[m.se + 1] = v % 10;
      end
      r.digit_count = 4'(m.len);
      // nibbles past the count are don't-care, so they get any value
      for (int i = 0; i < 14; i++)
         r.digits_bcd[55 - 4 * i -: 4] = 4'((i < m.len) ? dig[i] : $urandom_range(15));
      // occasionally break the sequence: wrong length or a non-decimal digit
      if ($urandom_range(31) == 0) r.digit_count = 4'($urandom_range(15));
      if ($urandom_range(31) == 0)
         r.digits_bcd[55 - 4 * $urandom_range(m.len - 1) -: 4] = 4'($urandom_range(15, 10));
      return r;
   endfunction

   function automatic req_type random_stamp();
      req_type r;
      r = '0;
      case ($urandom_range(9))
         // pure noise across all bits and counts
         0: begin
            r.digits_bcd  = 56'({$urandom, $urandom});
            r.digit_count = 4'($urandom_range(15));
         end
         // decimal digits without any layout in mind
         1: begin
            for (int i = 0; i < 14; i++)
               r.digits_bcd[55 - 4 * i -: 4] = 4'($urandom_range(9));
            r.digit_count = 4'(2 * $urandom_range(7, 3));
         end
         default: r = compose_stamp(layout_type'($urandom_range(NumLayouts - 1)));
      endcase
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance;
   // valid stays high between back-to-back items
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      ledger.note_stamp(item);
      @(negedge clock);
   endtask

   // stop sending and let every item in flight come out
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (ledger.pending_fields.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_pivot(input logic [6:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      ledger.set_pivot(value);
   endtask

   initial begin
      req_type     probe;
      logic [6:0]  pivot_plan[6];
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      reset         = 1'b1;
      send_idle_pct = 34;
      recv_idle_pct = 73;
      // phase 0 runs on the reset pivot; 127 is past the documented range
      pivot_plan = '{PIVOT_AT_RESET, 7'd0, 7'd99, 7'd127, 7'($urandom_range(99)), 7'd70};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         // receiver slow first, then sender slow, then full rate
         if (phase == 2) begin
            send_idle_pct = 73;
            recv_idle_pct = 34;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase > 0) begin
            drain_pipeline();
            write_pivot(pivot_plan[phase]);
         end else begin
            foreach (directed_text[i]) send_item(text_stamp(directed_text[i]));
            // non-decimal nibbles beyond the count must be ignored
            probe = text_stamp("235959");
            probe.digits_bcd[31:0] = '1;
            send_item(probe);
         end
         repeat (325) send_item(random_stamp());
      end

      drain_pipeline();
      if (ledger.clean()) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/ctd_pkg.sv
src/ctd_pair_stage.sv
src/ctd_check_stage.sv
src/ctd_select_stage.sv
src/compact_timestamp_decoder_unit.sv
src/ctd_checker.sv
tb/sv/ctd_tb_pkg.sv
tb/sv/tb_top.sv
